// ===== sv/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfd_pkg: shared types and constants for the websocket frame deframer
// Parse phases, result kinds, control opcodes, length codes, byte counts and the length width.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // width of the payload length counter (16 to 64)
  localparam int unsigned LEN_BITS = 64;

  // header parse phases
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DROP    = 3'd5
  } phase_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_PING  = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_t;

  // control frame opcodes
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // 7-bit length codes that select an extended length
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // extended length and masking key byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

endpackage

// ===== sv/websocket_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit: receive-side websocket frame parser
// Parses header, extended length and masking key one byte per word, then
// unmasks data payload bytes and reports ping, close and empty-frame events.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                          | tuser       | tlast
//  in_     | slave     | [7:0] byte                     | frame_start | -
//  out_    | master    | [7:0] byte [8] fin [12:9] opc  | [1:0] kind  | last
//
//  one input word per cycle while the output is not stalled; a word is held in
//  the input register and its result, if any, is registered in the output register
//  the state update (64-bit length decrement and compare) sets the cycle
//  reset clears the parser to expect a first header byte and empties both
//  registers; an output stall holds the result and stops the input register
//  only once it is full and its word would give a result
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit
  import wsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] out_fin, [12:9] out_opcode, zero pad
  output logic [1:0]  out_tuser,  // [1:0] out_kind
  output logic        out_tlast   // out_last
);

  // input register
  logic               s_valid_r;
  logic [7:0]         s_byte_r;
  logic               s_start_r;

  // parser state
  phase_t              phase_r, phase_nxt;
  logic                fin_r, fin_nxt;
  logic [3:0]          opcode_r, opcode_nxt;
  logic                mask_r, mask_nxt;
  logic [3:0]          ext_left_r, ext_left_nxt;
  logic [31:0]         key_r, key_nxt;
  logic [2:0]          key_left_r, key_left_nxt;
  logic [1:0]          key_idx_r, key_idx_nxt;
  logic [LEN_BITS-1:0] rem_r, rem_nxt;

  // result register
  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [7:0]  out_byte_r;
  logic        out_fin_r;
  logic [3:0]  out_opcode_r;
  logic        out_last_r;

  // step outputs
  logic        fire;
  logic        emit;
  kind_t       kind;
  logic [7:0]  res_byte;
  logic        res_last;
  logic        len_done;
  logic        hdr_done;
  phase_t      ph;
  logic [6:0]  len7;
  logic [LEN_BITS-1:0] rem_dec;

  // the held word moves on when it gives no result or the output has room
  assign fire      = s_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready = !s_valid_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s_byte_r  <= in_tdata;
      s_start_r <= in_tuser;
    end
  end

  // one parse step on the held word
  always_comb begin
    phase_nxt    = phase_r;
    fin_nxt      = fin_r;
    opcode_nxt   = opcode_r;
    mask_nxt     = mask_r;
    ext_left_nxt = ext_left_r;
    key_nxt      = key_r;
    key_left_nxt = key_left_r;
    key_idx_nxt  = key_idx_r;
    rem_nxt      = rem_r;
    emit         = 1'b0;
    kind         = KIND_DATA;
    res_byte     = 8'd0;
    res_last     = 1'b0;
    len_done     = 1'b0;
    hdr_done     = 1'b0;
    len7         = s_byte_r[6:0];
    rem_dec      = rem_r - LEN_BITS'(1);
    ph           = s_start_r ? PH_HDR0 : phase_r;

    case (ph)
      PH_HDR1: begin
        mask_nxt = s_byte_r[7];
        if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
          ext_left_nxt = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          rem_nxt      = '0;
          phase_nxt    = PH_EXT;
        end else begin
          rem_nxt  = LEN_BITS'(len7);
          len_done = 1'b1;
        end
      end
      PH_EXT: begin
        // saturate once the length would overflow the counter
        if (rem_r[LEN_BITS-1 -: 8] != 8'd0) begin
          rem_nxt = '1;
        end else begin
          rem_nxt = {rem_r[LEN_BITS-9:0], s_byte_r};
        end
        ext_left_nxt = ext_left_r - 4'd1;
        len_done     = (ext_left_nxt == 4'd0);
      end
      PH_KEY: begin
        key_nxt      = {key_r[23:0], s_byte_r};
        key_left_nxt = key_left_r - 3'd1;
        hdr_done     = (key_left_nxt == 3'd0);
      end
      PH_PAYLOAD: begin
        res_byte = s_byte_r;
        if (mask_r) begin
          case (key_idx_r)
            2'd0:    res_byte = s_byte_r ^ key_r[31:24];
            2'd1:    res_byte = s_byte_r ^ key_r[23:16];
            2'd2:    res_byte = s_byte_r ^ key_r[15:8];
            default: res_byte = s_byte_r ^ key_r[7:0];
          endcase
        end
        key_idx_nxt = key_idx_r + 2'd1;
        rem_nxt     = rem_dec;
        res_last    = (rem_dec == '0);
        if (res_last) begin
          phase_nxt = PH_HDR0;
        end
        emit = 1'b1;
        kind = KIND_DATA;
      end
      PH_DROP: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        // first header byte, also any unused phase code
        fin_nxt      = s_byte_r[7];
        opcode_nxt   = s_byte_r[3:0];
        mask_nxt     = 1'b0;
        ext_left_nxt = 4'd0;
        key_left_nxt = 3'd0;
        key_idx_nxt  = 2'd0;
        rem_nxt      = '0;
        phase_nxt    = PH_HDR1;
      end
    endcase

    // length complete: masking key next, or header complete
    if (len_done) begin
      if (mask_nxt) begin
        key_left_nxt = KEY_BYTES;
        phase_nxt    = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // header complete: control events, empty frames or payload
    if (hdr_done) begin
      key_idx_nxt = 2'd0;
      if (opcode_r == OP_PING || opcode_r == OP_CLOSE) begin
        phase_nxt = (rem_nxt != '0) ? PH_DROP : PH_HDR0;
        emit      = 1'b1;
        kind      = (opcode_r == OP_PING) ? KIND_PING : KIND_CLOSE;
        res_last  = 1'b1;
      end else if (rem_nxt == '0) begin
        phase_nxt = PH_HDR0;
        emit      = 1'b1;
        kind      = KIND_EMPTY;
        res_last  = 1'b1;
      end else begin
        phase_nxt = PH_PAYLOAD;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      fin_r      <= 1'b0;
      opcode_r   <= 4'd0;
      mask_r     <= 1'b0;
      ext_left_r <= 4'd0;
      key_r      <= 32'd0;
      key_left_r <= 3'd0;
      key_idx_r  <= 2'd0;
      rem_r      <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      fin_r      <= fin_nxt;
      opcode_r   <= opcode_nxt;
      mask_r     <= mask_nxt;
      ext_left_r <= ext_left_nxt;
      key_r      <= key_nxt;
      key_left_r <= key_left_nxt;
      key_idx_r  <= key_idx_nxt;
      rem_r      <= rem_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_kind_r   <= kind;
      out_byte_r   <= res_byte;
      out_fin_r    <= fin_r;
      out_opcode_r <= opcode_r;
      out_last_r   <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_opcode_r, out_fin_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/wsfd_checker.sv =====
// ----------------------------------------------------------------------------
// wsfd_checker: port-level checks for the websocket frame deframer
// Watches the result channel for stall behaviour and event consistency.
// ----------------------------------------------------------------------------
module wsfd_checker
  import wsfd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // events are last and carry a zero byte
  a_event_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DATA |-> out_tlast && out_tdata[7:0] == 8'd0)
    else $error("event word malformed");

  // event kind agrees with the frame opcode
  a_event_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DATA |->
      (out_tuser == KIND_PING && out_tdata[12:9] == OP_PING) ||
      (out_tuser == KIND_CLOSE && out_tdata[12:9] == OP_CLOSE) ||
      (out_tuser == KIND_EMPTY && out_tdata[12:9] != OP_PING
        && out_tdata[12:9] != OP_CLOSE))
    else $error("event kind does not match opcode");

  // payload words never come from control frames
  a_data_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DATA |->
      out_tdata[12:9] != OP_PING && out_tdata[12:9] != OP_CLOSE)
    else $error("payload word from a control frame");

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (.*);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the websocket frame deframer
// Feeds a byte stream of directed and random frames (masked and unmasked,
// short, 16-bit and 64-bit lengths, control frames, reserved opcodes, cut
// frames, noise and forced restarts). Each accepted byte runs through a
// local deframer model, and every output word is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;
  import wsfd_pkg::*;

  // frame opcodes the stimulus uses by name, besides ping and close
  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_TEXT = 4'h1;
  localparam logic [3:0] OP_BIN  = 4'h2;
  localparam logic [3:0] OP_PONG = 4'hA;
  localparam logic [3:0] OP_RSVD = 4'hF;

  // length encodings of the second header byte
  localparam int FORM_SHORT = 0;
  localparam int FORM_EXT16 = 1;
  localparam int FORM_EXT64 = 2;

  localparam int N_STREAM    = 1400;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_PRINTS  = 40;
  localparam logic [LEN_BITS-1:0] LEN_ALL = '1;

  typedef struct packed {
    logic [7:0] octet;
    logic       restart;
  } rx_octet_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       fin;
    logic [3:0] opc;
    logic       last;
  } deframed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] in_byte
  logic        in_tuser = 1'b0;    // [0] frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [7:0] out_byte, [8] out_fin, [12:9] out_opcode, zero pad
  logic [1:0]  out_tuser;          // [1:0] out_kind
  logic        out_tlast;

  rx_octet_t rx_stream_q[$];
  deframed_t deframed_q[$];

  logic in_fire = 1'b0;
  int   n_sent = 0;
  int   n_words = 0;
  int   n_errors = 0;
  int   idle_cycles = 0;
  int   n_kind[4] = '{0, 0, 0, 0};
  logic calm;

  // model state of the parser
  phase_t              rx_phase = PH_HDR0;
  logic                rx_fin = 1'b0;
  logic [3:0]          rx_opc = 4'h0;
  logic                rx_masked = 1'b0;
  logic [3:0]          rx_ext_left = 4'h0;
  logic [31:0]         rx_key = 32'h0;
  logic [2:0]          rx_key_left = 3'h0;
  logic [1:0]          rx_key_idx = 2'h0;
  logic [LEN_BITS-1:0] rx_len = '0;

  websocket_frame_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // no idling on either side for a stretch of the stream
  assign calm = (n_sent >= 600) && (n_sent < 900);

  // ---------------------------------------------------------------------------
  // deframer model
  // ---------------------------------------------------------------------------

  function automatic deframed_t make_word(input kind_t kind, input logic [7:0] data,
                                          input logic last);
    deframed_t w;
    w.kind = kind;
    w.data = data;
    w.fin  = rx_fin;
    w.opc  = rx_opc;
    w.last = last;
    return w;
  endfunction

  // header complete: control and empty frames report at once
  function automatic logic finish_header(output deframed_t res);
    res = make_word(KIND_DATA, 8'h00, 1'b0);
    rx_key_idx = 2'd0;
    if (rx_opc == OP_PING || rx_opc == OP_CLOSE) begin
      rx_phase = (rx_len != '0) ? PH_DROP : PH_HDR0;
      res = make_word((rx_opc == OP_PING) ? KIND_PING : KIND_CLOSE, 8'h00, 1'b1);
      return 1'b1;
    end
    if (rx_len == '0) begin
      rx_phase = PH_HDR0;
      res = make_word(KIND_EMPTY, 8'h00, 1'b1);
      return 1'b1;
    end
    rx_phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  // length complete: masked frames go on to the key
  function automatic logic finish_length(output deframed_t res);
    res = make_word(KIND_DATA, 8'h00, 1'b0);
    if (rx_masked) begin
      rx_key_left = KEY_BYTES;
      rx_phase = PH_KEY;
      return 1'b0;
    end
    return finish_header(res);
  endfunction

  // one received byte through the parser; returns 1 when it yields a word
  function automatic logic deframe_octet(input logic [7:0] b, input logic restart,
                                         output deframed_t res);
    phase_t     ph;
    logic [6:0] len7;
    logic [7:0] v;
    logic       hit;
    ph = restart ? PH_HDR0 : rx_phase;
    hit = 1'b0;
    res = make_word(KIND_DATA, 8'h00, 1'b0);
    case (ph)
      PH_HDR1: begin
        len7 = b[6:0];
        rx_masked = b[7];
        if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
          rx_ext_left = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          rx_len = '0;
          rx_phase = PH_EXT;
        end else begin
          rx_len = LEN_BITS'(len7);
          hit = finish_length(res);
        end
      end
      PH_EXT: begin
        // saturate a length too wide for the counter
        if (rx_len > (LEN_ALL >> 8)) rx_len = LEN_ALL;
        else rx_len = {rx_len[LEN_BITS-9:0], b};
        rx_ext_left = rx_ext_left - 4'd1;
        if (rx_ext_left == 4'd0) hit = finish_length(res);
      end
      PH_KEY: begin
        rx_key = {rx_key[23:0], b};
        rx_key_left = rx_key_left - 3'd1;
        if (rx_key_left == 3'd0) hit = finish_header(res);
      end
      PH_PAYLOAD: begin
        v = b;
        if (rx_masked) v = v ^ rx_key[8*(3-rx_key_idx) +: 8];
        rx_key_idx = rx_key_idx + 2'd1;
        rx_len = rx_len - 1'b1;
        if (rx_len == '0) rx_phase = PH_HDR0;
        res = make_word(KIND_DATA, v, rx_len == '0);
        hit = 1'b1;
      end
      PH_DROP: begin
        rx_len = rx_len - 1'b1;
        if (rx_len == '0) rx_phase = PH_HDR0;
      end
      default: begin
        rx_fin = b[7];
        rx_opc = b[3:0];
        rx_masked = 1'b0;
        rx_ext_left = 4'd0;
        rx_key_left = 3'd0;
        rx_key_idx = 2'd0;
        rx_len = '0;
        rx_phase = PH_HDR1;
      end
    endcase
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // stream building
  // ---------------------------------------------------------------------------

  task automatic stream_push(input logic [7:0] octet, input logic restart);
    rx_octet_t o;
    o.octet = octet;
    o.restart = restart;
    rx_stream_q = {rx_stream_q, o};
  endtask

  // one frame with random key and payload, optionally cut after some bytes
  task automatic queue_frame(input logic lead, input logic [7:0] hdr0, input logic masked,
                             input int form, input logic [63:0] len, input int body_n,
                             input int cut);
    logic [7:0]  frm[$];
    logic [31:0] key;
    int          n;
    key = $urandom;
    frm = {frm, hdr0};
    case (form)
      FORM_SHORT: frm = {frm, {masked, len[6:0]}};
      FORM_EXT16: begin
        frm = {frm, {masked, LEN7_EXT16}};
        frm = {frm, len[15:8]};
        frm = {frm, len[7:0]};
      end
      default: begin
        frm = {frm, {masked, LEN7_EXT64}};
        for (int i = 7; i >= 0; i--) frm = {frm, len[8*i +: 8]};
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) frm = {frm, key[8*i +: 8]};
    for (int i = 0; i < body_n; i++) frm = {frm, 8'($urandom_range(0, 255))};
    n = (cut > 0 && cut < frm.size()) ? cut : frm.size();
    for (int i = 0; i < n; i++) stream_push(frm[i], (i == 0) ? lead : 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_errors < MAX_PRINTS)
      $display("mismatch at word %0d: %s got %0h want %0h", n_words, what, got, want);
    n_errors++;
  endtask

  // sample both channels, predict and compare, and guard against a hang
  always @(posedge clk) begin : watch
    deframed_t want;
    deframed_t got;
    if (!rst_n) begin
      in_fire <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (deframed_q.size() == 0) begin
          report_mismatch("word with nothing expected, tdata", int'(out_tdata), 0);
        end else begin
          want = deframed_q.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch("kind", int'(out_tuser), int'(want.kind));
          if (out_tdata[7:0] !== want.data)
            report_mismatch("byte", int'(out_tdata[7:0]), int'(want.data));
          if (out_tdata[8] !== want.fin)
            report_mismatch("fin", int'(out_tdata[8]), int'(want.fin));
          if (out_tdata[12:9] !== want.opc)
            report_mismatch("opcode", int'(out_tdata[12:9]), int'(want.opc));
          if (out_tdata[15:13] !== 3'b000)
            report_mismatch("pad", int'(out_tdata[15:13]), 0);
          if (out_tlast !== want.last)
            report_mismatch("last", int'(out_tlast), int'(want.last));
          n_kind[want.kind]++;
        end
        n_words++;
      end
      if (in_tvalid && in_tready) begin
        if (deframe_octet(in_tdata, in_tuser, got)) deframed_q = {deframed_q, got};
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("no word moved for %0d cycles, %0d results outstanding",
                 idle_cycles, deframed_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: input words from the stream queue, random idles on both sides
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : drive
    rx_octet_t cur;
    if (rst_n) begin
      if (!in_tvalid || in_fire) begin
        if (rx_stream_q.size() > 0 && (calm || $urandom_range(0, 99) >= 33)) begin
          cur = rx_stream_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= cur.octet;
          in_tuser <= cur.restart;
          n_sent <= n_sent + 1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [7:0]  hdr;
    logic [63:0] len;
    logic        masked;
    logic        lead_restart;
    int          form;
    int          pick;

    // unmasked data byte passes unchanged and is last
    stream_push({1'b1, 3'b000, OP_BIN}, 1'b0);
    stream_push({1'b0, 7'd1}, 1'b0);
    stream_push(8'hFF, 1'b0);
    // ping with payload: event on the length byte, payload dropped
    stream_push({1'b1, 3'b000, OP_PING}, 1'b0);
    stream_push({1'b0, 7'd1}, 1'b0);
    stream_push(8'hA5, 1'b0);
    // masked close of length zero: event on the last key byte
    stream_push({1'b1, 3'b000, OP_CLOSE}, 1'b0);
    stream_push({1'b1, 7'd0}, 1'b0);
    stream_push(8'h00, 1'b0);
    stream_push(8'hFF, 1'b0);
    stream_push(8'h5A, 1'b0);
    stream_push(8'h3C, 1'b0);
    // empty text frame via the 16-bit length form
    stream_push({1'b0, 3'b000, OP_TEXT}, 1'b0);
    stream_push({1'b0, LEN7_EXT16}, 1'b0);
    stream_push(8'h00, 1'b0);
    stream_push(8'h00, 1'b0);
    // reserved opcode with rsv bits and a huge length, abandoned mid-length
    stream_push({1'b1, 3'b111, OP_RSVD}, 1'b0);
    stream_push({1'b1, LEN7_EXT64}, 1'b0);
    stream_push(8'hFF, 1'b0);
    stream_push(8'hFF, 1'b0);
    stream_push(8'hFF, 1'b0);
    // forced restart into a masked pong, handled as data
    stream_push({1'b0, 3'b000, OP_PONG}, 1'b1);
    stream_push({1'b1, 7'd1}, 1'b0);
    stream_push(8'h12, 1'b0);
    stream_push(8'h34, 1'b0);
    stream_push(8'h56, 1'b0);
    stream_push(8'h78, 1'b0);
    stream_push(8'h9B, 1'b0);

    // random frames, mostly well formed, some cut, some noise
    lead_restart = 1'b0;
    while (rx_stream_q.size() < N_STREAM) begin
      hdr = 8'($urandom);
      case ($urandom_range(0, 9))
        0, 1: hdr[3:0] = OP_TEXT;
        2, 3: hdr[3:0] = OP_BIN;
        4: hdr[3:0] = OP_CONT;
        5: hdr[3:0] = OP_PING;
        6: hdr[3:0] = OP_CLOSE;
        default: ;
      endcase
      masked = 1'($urandom_range(0, 1));
      pick = int'($urandom_range(0, 19));
      if (pick < 15) begin
        form = FORM_SHORT;
        len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 125))
                                          : 64'($urandom_range(0, 12));
      end else if (pick < 18) begin
        form = FORM_EXT16;
        len = 64'($urandom_range(0, 200));
      end else begin
        form = FORM_EXT64;
        len = 64'($urandom_range(0, 40));
      end
      if (!lead_restart) lead_restart = 1'($urandom_range(0, 1));
      pick = int'($urandom_range(0, 99));
      if (pick < 70) begin
        queue_frame(lead_restart, hdr, masked, form, len, int'(len), -1);
        lead_restart = 1'b0;
      end else if (pick < 85) begin
        queue_frame(lead_restart, hdr, masked, form, len, int'(len),
                    int'($urandom_range(1, 12)));
        lead_restart = 1'b1;
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6))
          stream_push(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        lead_restart = 1'b1;
      end else begin
        len = {$urandom, $urandom};
        queue_frame(lead_restart, hdr, masked, FORM_EXT64, len,
                    int'($urandom_range(0, 8)), -1);
        lead_restart = 1'b1;
      end
    end

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    while (rx_stream_q.size() != 0 || in_tvalid || deframed_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("fed %0d stream bytes through the deframer, %0d output words checked",
             n_sent, n_words);
    $display("  payload %0d, empty frame %0d, ping %0d, close %0d",
             n_kind[KIND_DATA], n_kind[KIND_EMPTY], n_kind[KIND_PING], n_kind[KIND_CLOSE]);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/wsfd_pkg.sv
sv/websocket_frame_deframer_unit.sv
sv/wsfd_checker.sv
test/tb_top.sv
